>>> rtl/nfc_pkg.sv
// Shared types and constants for the NAND flash controller: array geometry,
// controller register offsets, command codes, result codes and payload structs.
// Depends on nothing; every RTL file imports it.
package nfc_pkg;

  // Array geometry
  localparam int    BLOCK_COUNT    = 2048;
  localparam int    PAGES_IN_BLOCK = 32;
  localparam int    PAGE_BYTES     = 528;
  localparam int    TOTAL_PAGES    = BLOCK_COUNT * PAGES_IN_BLOCK;
  localparam int    BLOCK_BYTES    = PAGES_IN_BLOCK * PAGE_BYTES;
  localparam longint STORE_BYTES   = longint'(TOTAL_PAGES) * longint'(PAGE_BYTES);

  // Derived widths
  localparam int ADDR_W  = $clog2(STORE_BYTES);
  localparam int BLK_W   = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
  localparam int WIPE_W  = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
  localparam int COUNT_W = $clog2(PAGE_BYTES + 1);
  localparam int OFF_W   = 10;

  // Second area of a page (Read C)
  localparam logic [OFF_W-1:0] AREA_C_OFFSET = 10'h200;

  // Operations carried by a request
  localparam logic [1:0] OP_REG_WRITE = 2'd0;
  localparam logic [1:0] OP_REG_READ  = 2'd1;
  localparam logic [1:0] OP_DATA_READ = 2'd2;
  localparam logic [1:0] OP_DATA_PROG = 2'd3;

  // Controller register offsets
  localparam logic [7:0] REG_CTRL0  = 8'h00;
  localparam logic [7:0] REG_CTRL1  = 8'h04;
  localparam logic [7:0] REG_START  = 8'h08;
  localparam logic [7:0] REG_CMD    = 8'h0C;
  localparam logic [7:0] REG_ADDR0  = 8'h10;
  localparam logic [7:0] REG_ADDR1  = 8'h14;
  localparam logic [7:0] REG_ADDR2  = 8'h18;
  localparam logic [7:0] REG_ADDR3  = 8'h1C;
  localparam logic [7:0] REG_SIZE   = 8'h24;
  localparam logic [7:0] REG_RAM    = 8'h28;
  localparam logic [7:0] REG_SPARE0 = 8'h2C;
  localparam logic [7:0] REG_SPARE1 = 8'h30;
  localparam logic [7:0] REG_ID     = 8'h34;
  localparam logic [7:0] REG_CFG0   = 8'h40;
  localparam logic [7:0] REG_CFG1   = 8'h44;
  localparam logic [7:0] REG_CFG2   = 8'h48;
  localparam logic [7:0] REG_CFG3   = 8'h4C;
  localparam logic [7:0] REG_CFG4   = 8'h50;
  localparam logic [7:0] REG_CFG5   = 8'h54;

  // Fixed read values
  localparam logic [31:0] ID_VALUE   = 32'h0000_0040;
  localparam logic [31:0] CFG0_VALUE = 32'h0000_0001;
  localparam logic [31:0] CFG1_VALUE = 32'h00FF_FFFF;

  // Flash command codes
  localparam logic [7:0] CMD_READ_A  = 8'h00;
  localparam logic [7:0] CMD_READ_C  = 8'h50;
  localparam logic [7:0] CMD_ERASE   = 8'h60;
  localparam logic [7:0] CMD_STATUS  = 8'h70;
  localparam logic [7:0] CMD_PROGRAM = 8'h80;
  localparam logic [7:0] CMD_SIG     = 8'h90;
  localparam logic [7:0] CMD_RESET   = 8'hFF;

  // Signature bytes and erased value
  localparam logic [7:0] SIG_BYTE0   = 8'h20;
  localparam logic [7:0] SIG_BYTE1   = 8'h35;
  localparam logic [7:0] ERASED_BYTE = 8'hFF;

  // Result codes
  localparam logic [3:0] ERR_OK          = 4'd0;
  localparam logic [3:0] ERR_BAD_REG     = 4'd1;
  localparam logic [3:0] ERR_READ_PAGE   = 4'd2;
  localparam logic [3:0] ERR_READ_LONG   = 4'd3;
  localparam logic [3:0] ERR_ERASE_BLOCK = 4'd4;
  localparam logic [3:0] ERR_PROG_PAGE   = 4'd5;
  localparam logic [3:0] ERR_PROG_LONG   = 4'd6;
  localparam logic [3:0] ERR_UNKNOWN_CMD = 4'd7;
  localparam logic [3:0] ERR_BAD_START   = 4'd8;
  localparam logic [3:0] ERR_NO_TRANSFER = 4'd9;

  // Pending data transfer kind
  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_READ = 2'd1,
    MODE_PROG = 2'd2,
    MODE_SIG  = 2'd3
  } xfer_mode_t;

  // One entry of the block table
  typedef struct packed {
    logic modified;
    logic dirty;
  } blk_entry_t;

  // Request and response payloads
  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  reg_offset;
    logic [31:0] write_value;
    logic [7:0]  data_byte;
  } nfc_req_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic [7:0]  data_out;
    logic [3:0]  error_code;
  } nfc_rsp_t;

endpackage

>>> rtl/nand_flash_controller.sv
// NAND flash controller top level: register bank, command sequencer, byte data
// memory and block table. Depends on nfc_pkg.
//
// Every request gives exactly one response. A request is taken only while the
// sequencer is idle, and the response register lets the next request in while
// a response still waits. Register reads and writes and data bytes are taken in
// S_IDLE, which also issues the data byte read of the data memory, and executed
// in S_EXEC against the registered memory data. A start that launches a read
// transfer goes on to S_RDSET for the block table read; a program start goes on
// to S_PGCHK, and on a block not written since its last erase then to S_WIPE,
// where the block's stale bytes are swept to 0xFF one per cycle through the data
// memory write port. Erase marks the block clean in the block table; a clean
// block reads as all 0xFF. After reset the block table is cleared one entry a
// cycle, all BLOCK_COUNT (2048) entries, before the first request is taken. A
// finished response that finds the output full is parked in S_RESULT until the
// output register frees up.
module nand_flash_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  nfc_pkg::nfc_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output nfc_pkg::nfc_rsp_t rsp
);
  import nfc_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_EXEC   = 7'b0000100,
    S_RDSET  = 7'b0001000,
    S_PGCHK  = 7'b0010000,
    S_WIPE   = 7'b0100000,
    S_RESULT = 7'b1000000
  } state_t;

  // Storage
  logic [7:0]  data_mem [STORE_BYTES];
  blk_entry_t  blk_mem  [BLOCK_COUNT];

  // Memory ports
  logic              dm_re, dm_we;
  logic [ADDR_W-1:0] dm_waddr;
  logic [7:0]        dm_wdata, dm_rdata;
  logic              bm_re, bm_we;
  logic [BLK_W-1:0]  bm_raddr, bm_waddr;
  blk_entry_t        bm_wdata, bm_rdata;

  // Registers and next values
  state_t             state, state_next;
  nfc_req_t           cur, cur_next;
  logic [7:0]         command_reg, command_reg_next;
  logic [31:0]        address_word, address_word_next;
  logic [31:0]        transfer_size, transfer_size_next;
  logic [31:0]        ram_address_reg, ram_address_reg_next;
  xfer_mode_t         mode, mode_next;
  logic [COUNT_W-1:0] remaining, remaining_next;
  logic [ADDR_W-1:0]  cell_addr, cell_addr_next;
  logic               cur_dirty, cur_dirty_next;
  logic [BLK_W-1:0]   blk_idx, blk_idx_next;
  logic [ADDR_W-1:0]  wipe_addr, wipe_addr_next;
  logic [WIPE_W-1:0]  wipe_cnt, wipe_cnt_next;
  logic [BLK_W-1:0]   clr_idx, clr_idx_next;
  nfc_rsp_t           res, res_next;
  nfc_rsp_t           rsp_next;
  logic               rsp_valid_next;

  // Decoded command operands
  logic [23:0]       rd_page;
  logic              page_ok;
  logic [OFF_W-1:0]  xfer_off;
  logic              len_bad;
  logic [ADDR_W-1:0] xfer_start;
  logic [BLK_W-1:0]  page_blk;
  logic              erase_ok;
  logic [BLK_W-1:0]  erase_blk;

  // Finish of a request
  logic     fin;
  nfc_rsp_t fin_res;
  logic     rsp_free;

  assign req_ready = (state == S_IDLE);
  assign rsp_free  = !rsp_valid || rsp_ready;

  // Decode page, offset and length checks from the address registers
  always_comb begin
    rd_page    = address_word[31:8];
    page_ok    = {8'b0, rd_page} < 32'(TOTAL_PAGES);
    xfer_off   = ((command_reg == CMD_READ_C) ? AREA_C_OFFSET : '0)
                 + {{(OFF_W-8){1'b0}}, address_word[7:0]};
    len_bad    = ({{(32-OFF_W){1'b0}}, xfer_off} > 32'(PAGE_BYTES))
                 || (transfer_size > (32'(PAGE_BYTES) - {{(32-OFF_W){1'b0}}, xfer_off}));
    xfer_start = ADDR_W'(rd_page) * ADDR_W'(PAGE_BYTES) + ADDR_W'(xfer_off);
    page_blk   = BLK_W'(rd_page / PAGES_IN_BLOCK);
    erase_ok   = (address_word < 32'(TOTAL_PAGES))
                 && ((address_word % PAGES_IN_BLOCK) == 0);
    erase_blk  = BLK_W'(address_word / PAGES_IN_BLOCK);
  end

  // Sequencer
  always_comb begin
    state_next           = state;
    cur_next             = cur;
    command_reg_next     = command_reg;
    address_word_next    = address_word;
    transfer_size_next   = transfer_size;
    ram_address_reg_next = ram_address_reg;
    mode_next            = mode;
    remaining_next       = remaining;
    cell_addr_next       = cell_addr;
    cur_dirty_next       = cur_dirty;
    blk_idx_next         = blk_idx;
    wipe_addr_next       = wipe_addr;
    wipe_cnt_next        = wipe_cnt;
    clr_idx_next         = clr_idx;
    res_next             = res;
    rsp_next             = rsp;
    rsp_valid_next       = rsp_valid && !rsp_ready;
    dm_re                = 1'b0;
    dm_we                = 1'b0;
    dm_waddr             = cell_addr;
    dm_wdata             = dm_rdata & cur.data_byte;
    bm_re                = 1'b0;
    bm_raddr             = page_blk;
    bm_we                = 1'b0;
    bm_waddr             = blk_idx;
    bm_wdata             = '{modified: 1'b1, dirty: 1'b1};
    fin                  = 1'b0;
    fin_res              = '{read_value: '0, data_out: '0, error_code: ERR_OK};

    unique case (state)
      // Sweep the block table clean after reset
      S_CLEAR: begin
        bm_we        = 1'b1;
        bm_waddr     = clr_idx;
        bm_wdata     = '{modified: 1'b0, dirty: 1'b0};
        clr_idx_next = clr_idx + 1'b1;
        if (clr_idx == BLK_W'(BLOCK_COUNT - 1)) begin
          state_next = S_IDLE;
        end
      end

      // Take a request; fetch the byte under the pointer in case it needs one
      S_IDLE: begin
        if (req_valid) begin
          cur_next   = req;
          dm_re      = 1'b1;
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        fin = 1'b1;
        unique case (cur.operation)
          OP_REG_WRITE: begin
            unique case (cur.reg_offset)
              REG_START: begin
                if (cur.write_value != 32'd1) begin
                  fin_res.error_code = ERR_BAD_START;
                end else begin
                  mode_next = MODE_NONE;
                  unique case (command_reg)
                    CMD_READ_A, CMD_READ_C: begin
                      if (!page_ok) begin
                        fin_res.error_code = ERR_READ_PAGE;
                      end else if (ram_address_reg == '0) begin
                        fin_res.error_code = ERR_OK;
                      end else if (len_bad) begin
                        fin_res.error_code = ERR_READ_LONG;
                      end else if (transfer_size != '0) begin
                        mode_next      = MODE_READ;
                        cell_addr_next = xfer_start;
                        remaining_next = COUNT_W'(transfer_size);
                        bm_re          = 1'b1;
                        fin            = 1'b0;
                        state_next     = S_RDSET;
                      end
                    end
                    CMD_ERASE: begin
                      if (!erase_ok) begin
                        fin_res.error_code = ERR_ERASE_BLOCK;
                      end else begin
                        bm_we    = 1'b1;
                        bm_waddr = erase_blk;
                        bm_wdata = '{modified: 1'b1, dirty: 1'b0};
                      end
                    end
                    CMD_PROGRAM: begin
                      if (!page_ok) begin
                        fin_res.error_code = ERR_PROG_PAGE;
                      end else if (len_bad) begin
                        fin_res.error_code = ERR_PROG_LONG;
                      end else begin
                        blk_idx_next = page_blk;
                        bm_re        = 1'b1;
                        fin          = 1'b0;
                        state_next   = S_PGCHK;
                        if (transfer_size != '0) begin
                          mode_next      = MODE_PROG;
                          cell_addr_next = xfer_start;
                          remaining_next = COUNT_W'(transfer_size);
                        end
                      end
                    end
                    CMD_SIG: begin
                      mode_next      = MODE_SIG;
                      cell_addr_next = '0;
                      remaining_next = COUNT_W'(2);
                    end
                    CMD_STATUS, CMD_RESET: begin
                      fin_res.error_code = ERR_OK;
                    end
                    default: begin
                      fin_res.error_code = ERR_UNKNOWN_CMD;
                    end
                  endcase
                end
              end
              REG_CMD:   command_reg_next = cur.write_value[7:0];
              REG_ADDR0: address_word_next[7:0]   = cur.write_value[7:0];
              REG_ADDR1: address_word_next[15:8]  = cur.write_value[7:0];
              REG_ADDR2: address_word_next[23:16] = cur.write_value[7:0];
              REG_ADDR3: address_word_next[31:24] = cur.write_value[7:0];
              REG_SIZE:  transfer_size_next   = cur.write_value;
              REG_RAM:   ram_address_reg_next = cur.write_value;
              REG_CTRL0, REG_CTRL1, REG_SPARE0, REG_SPARE1,
              REG_CFG0, REG_CFG1, REG_CFG2, REG_CFG3, REG_CFG4, REG_CFG5: begin
                fin_res.error_code = ERR_OK;
              end
              default: fin_res.error_code = ERR_BAD_REG;
            endcase
          end

          OP_REG_READ: begin
            unique case (cur.reg_offset)
              REG_CTRL0, REG_START: fin_res.read_value = '0;
              REG_ID:   fin_res.read_value = ID_VALUE;
              REG_CFG0: fin_res.read_value = CFG0_VALUE;
              REG_CFG1: fin_res.read_value = CFG1_VALUE;
              default:  fin_res.error_code = ERR_BAD_REG;
            endcase
          end

          // Deliver one byte of a read or signature transfer
          OP_DATA_READ: begin
            if (mode == MODE_READ && remaining != '0) begin
              fin_res.data_out = cur_dirty ? dm_rdata : ERASED_BYTE;
              cell_addr_next   = cell_addr + 1'b1;
              remaining_next   = remaining - 1'b1;
              if (remaining == COUNT_W'(1)) mode_next = MODE_NONE;
            end else if (mode == MODE_SIG && remaining != '0) begin
              fin_res.data_out = (cell_addr == '0) ? SIG_BYTE0 : SIG_BYTE1;
              cell_addr_next   = cell_addr + 1'b1;
              remaining_next   = remaining - 1'b1;
              if (remaining == COUNT_W'(1)) mode_next = MODE_NONE;
            end else begin
              fin_res.error_code = ERR_NO_TRANSFER;
            end
          end

          // AND one byte into the page and write it back
          OP_DATA_PROG: begin
            if (mode == MODE_PROG && remaining != '0) begin
              dm_we          = 1'b1;
              cell_addr_next = cell_addr + 1'b1;
              remaining_next = remaining - 1'b1;
              if (remaining == COUNT_W'(1)) mode_next = MODE_NONE;
            end else begin
              fin_res.error_code = ERR_NO_TRANSFER;
            end
          end
        endcase
      end

      // Latch whether the read block holds written data
      S_RDSET: begin
        cur_dirty_next = bm_rdata.dirty;
        fin            = 1'b1;
      end

      // Mark the block written; sweep stale bytes first if it was clean
      S_PGCHK: begin
        if (bm_rdata.dirty) begin
          bm_we = 1'b1;
          fin   = 1'b1;
        end else begin
          wipe_addr_next = ADDR_W'(blk_idx) * ADDR_W'(BLOCK_BYTES);
          wipe_cnt_next  = '0;
          state_next     = S_WIPE;
        end
      end

      S_WIPE: begin
        dm_we          = 1'b1;
        dm_waddr       = wipe_addr;
        dm_wdata       = ERASED_BYTE;
        wipe_addr_next = wipe_addr + 1'b1;
        wipe_cnt_next  = wipe_cnt + 1'b1;
        if (wipe_cnt == WIPE_W'(BLOCK_BYTES - 1)) begin
          bm_we = 1'b1;
          fin   = 1'b1;
        end
      end

      // Hold a finished response until the output register frees up
      S_RESULT: begin
        if (rsp_free) begin
          rsp_next       = res;
          rsp_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase

    // Hand the response over, or park it
    if (fin) begin
      if (rsp_free) begin
        rsp_next       = fin_res;
        rsp_valid_next = 1'b1;
        state_next     = S_IDLE;
      end else begin
        res_next   = fin_res;
        state_next = S_RESULT;
      end
    end
  end

  // Data memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (dm_we) begin
      data_mem[dm_waddr] <= dm_wdata;
    end
    if (dm_re) begin
      dm_rdata <= data_mem[cell_addr];
    end
  end

  // Block table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (bm_we) begin
      blk_mem[bm_waddr] <= bm_wdata;
    end
    if (bm_re) begin
      bm_rdata <= blk_mem[bm_raddr];
    end
  end

  // Control and register state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_CLEAR;
      clr_idx         <= '0;
      command_reg     <= '0;
      address_word    <= '0;
      transfer_size   <= '0;
      ram_address_reg <= '0;
      mode            <= MODE_NONE;
      remaining       <= '0;
      cell_addr       <= '0;
      rsp_valid       <= 1'b0;
    end else begin
      state           <= state_next;
      clr_idx         <= clr_idx_next;
      command_reg     <= command_reg_next;
      address_word    <= address_word_next;
      transfer_size   <= transfer_size_next;
      ram_address_reg <= ram_address_reg_next;
      mode            <= mode_next;
      remaining       <= remaining_next;
      cell_addr       <= cell_addr_next;
      rsp_valid       <= rsp_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur       <= cur_next;
    cur_dirty <= cur_dirty_next;
    blk_idx   <= blk_idx_next;
    wipe_addr <= wipe_addr_next;
    wipe_cnt  <= wipe_cnt_next;
    res       <= res_next;
    rsp       <= rsp_next;
  end

  // A pending transfer always has bytes left
  a_mode_has_count: assert property (@(posedge clk) disable iff (rst)
    (mode != MODE_NONE) |-> (remaining != '0))
    else $error("transfer pending with zero byte count");

  // A parked response only waits behind a full output register
  a_result_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESULT) |-> rsp_valid)
    else $error("parked response with empty output register");

  // The data memory is written only by a program byte or the block sweep
  a_dm_write_src: assert property (@(posedge clk) disable iff (rst)
    dm_we |-> ((state == S_EXEC) || (state == S_WIPE)))
    else $error("data memory written outside program or sweep");

  // A taken request is executed in the next cycle
  a_take_exec: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state == S_EXEC))
    else $error("taken request not executed");

endmodule
